FILE: sv/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_AT(lbl, clk_sig, rst_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, expr) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_AT(lbl, clk_sig, rst_sig, prop)
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, expr)
`endif

`endif

FILE: sv/srb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

    localparam int unsigned CAPACITY = 4096;
    localparam int unsigned ADDR_W   = $clog2(CAPACITY);
    localparam logic [31:0] CAP_32   = 32'(CAPACITY);

    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_END  = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_NOP  = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] stream_index;
        logic [7:0]  data_byte;
    } req_t;

    typedef struct packed {
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        accepted;
        logic [12:0] assembled_count;
        logic [12:0] pending_count;
        logic        stream_ended;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC,
        ST_ADV_RD,
        ST_ADV_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic lookup;
        logic exec;
        logic adv_rd;
        logic adv_step;
        logic clear_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic adv_go;
        logic adv_hit;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: sv/srb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module srb_ctrl
    import srb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_ADV_RD;
            end
            ST_ADV_RD:
            begin
                if (status.adv_go)
                begin
                    cmd.adv_rd = 1'b1;
                    state_next = ST_ADV_CHK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ADV_CHK:
            begin
                cmd.adv_step = 1'b1;
                state_next   = status.adv_hit ? ST_ADV_RD : ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/srb_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module srb_dp
    import srb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t req,
    input  wire cmd_t cmd,
    input  wire logic rsp_stall,
    output status_t   status,
    output logic      rsp_valid,
    output rsp_t      rsp
);

    // slot store: {valid, byte}
    logic [8:0] mem [CAPACITY];
    logic [8:0] mem_q;

    req_t              item_reg;
    logic [31:0]       next_exp_reg;
    logic [31:0]       rd_count_reg;
    logic              end_known_reg;
    logic [31:0]       end_index_reg;
    logic [12:0]       pending_reg;
    logic              acc_reg;
    logic              rvalid_reg;
    logic [7:0]        rbyte_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;

    logic [31:0]       assembled;
    logic [31:0]       offset;
    logic              at_end;
    logic              beyond_end;
    logic              push_ok;
    logic              read_ok;
    logic [ADDR_W-1:0] op_addr;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [8:0]        wdata;
    logic              we;
    logic              re;

    assign assembled  = next_exp_reg - rd_count_reg;
    assign offset     = item_reg.stream_index - rd_count_reg;
    assign at_end     = end_known_reg && (next_exp_reg >= end_index_reg);
    assign beyond_end = end_known_reg && (item_reg.stream_index >= end_index_reg);

    assign push_ok = (item_reg.func == FUNC_PUSH) && !beyond_end && (offset >= assembled)
                     && (offset < CAP_32) && !mem_q[8];
    assign read_ok = (item_reg.func == FUNC_READ) && (assembled != 32'd0);

    assign op_addr = (item_reg.func == FUNC_READ) ? rd_count_reg[ADDR_W-1:0]
                                                  : item_reg.stream_index[ADDR_W-1:0];
    assign raddr   = cmd.lookup ? op_addr : next_exp_reg[ADDR_W-1:0];
    assign re      = cmd.lookup || cmd.adv_rd;
    assign we      = cmd.clear_step || (cmd.exec && (push_ok || read_ok));
    assign waddr   = cmd.clear_step ? clr_cnt_reg : op_addr;
    assign wdata   = cmd.clear_step ? 9'd0
                   : (push_ok ? {1'b1, item_reg.data_byte} : {1'b0, mem_q[7:0]});

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            mem_q <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req;
        end
        if (cmd.load_out)
        begin
            out_reg.read_valid      <= rvalid_reg;
            out_reg.read_byte       <= rbyte_reg;
            out_reg.accepted        <= acc_reg;
            out_reg.assembled_count <= assembled[12:0];
            out_reg.pending_count   <= pending_reg;
            out_reg.stream_ended    <= at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_exp_reg  <= '0;
            rd_count_reg  <= '0;
            end_known_reg <= 1'b0;
            end_index_reg <= '0;
            pending_reg   <= '0;
            acc_reg       <= 1'b0;
            rvalid_reg    <= 1'b0;
            rbyte_reg     <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                acc_reg    <= push_ok;
                rvalid_reg <= read_ok;
                rbyte_reg  <= read_ok ? mem_q[7:0] : 8'd0;
                if (push_ok)
                begin
                    pending_reg <= pending_reg + 13'd1;
                end
                if (read_ok)
                begin
                    rd_count_reg <= rd_count_reg + 32'd1;
                end
                if (item_reg.func == FUNC_END)
                begin
                    end_known_reg <= 1'b1;
                    end_index_reg <= item_reg.stream_index;
                end
            end
            if (cmd.adv_step && mem_q[8])
            begin
                next_exp_reg <= next_exp_reg + 32'd1;
                if (pending_reg != 13'd0)
                begin
                    pending_reg <= pending_reg - 13'd1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_last = (clr_cnt_reg == {ADDR_W{1'b1}});
    assign status.adv_go     = (assembled < CAP_32) && !at_end;
    assign status.adv_hit    = mem_q[8];
    assign status.out_free   = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

FILE: sv/stream_byte_reassembler.sv
// Byte stream reassembler over a 4096-slot ring. Each request (push a byte at
// its stream index, mark the end index, or read one assembled byte) returns
// one response with the counts after it. A request passes the lookup and
// execute steps, then the advance steps, a slot read and a check for every
// byte the front moves over, and last the done step. The advance cost comes
// from the registered lookup of the slot store that comes before each
// advance check. A request also waits in the last step while the previous
// response is still held by rsp_stall. After reset a clearing pass over the
// 4096 slots empties the slot store before the first request is taken. A new
// request may enter while the previous response still waits on rsp_stall.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stream_byte_reassembler
    import srb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    cmd_t    cmd;
    status_t status;

    srb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    srb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    `ASSERT_AT(a_one_at_a_time, clk, rst_n, (req_valid && !req_stall) |=> req_stall)
    `ASSERT_NEVER(a_read_and_push, clk, rst_n, rsp_valid && rsp.read_valid && rsp.accepted)
    `ASSERT_NEVER(a_assembled_range, clk, rst_n, rsp_valid && (rsp.assembled_count > 13'd4096))

endmodule

`default_nettype wire

FILE: tb/sv/stream_byte_reassembler_test.sv
`timescale 1ns / 1ps

module stream_byte_reassembler_test;
    import srb_pkg::*;

    localparam int IDLE_CAP   = 40000;
    localparam int RAND_COUNT = 1750;

    class reassembly_scoreboard;
        logic [7:0]  ring_bytes [CAPACITY];
        bit          slot_full [CAPACITY];
        logic [31:0] front_idx;
        logic [31:0] read_total;
        bit          end_seen;
        logic [31:0] end_at;
        logic [31:0] pending;
        rsp_t        expected_q [$];
        int          mismatches;

        function new();
            for (int i = 0; i < CAPACITY; i++)
                slot_full[i] = 1'b0;
            front_idx = '0;
            read_total = '0;
            end_seen = 1'b0;
            end_at = '0;
            pending = '0;
            mismatches = 0;
        endfunction

        function bit front_stopped();
            return end_seen && front_idx >= end_at;
        endfunction

        function void note_request(req_t r);
            rsp_t        e;
            logic [31:0] off;
            logic [31:0] slot;
            e = '0;
            if (r.func == FUNC_PUSH)
            begin
                off = r.stream_index - read_total;
                slot = r.stream_index % CAPACITY;
                if (!(end_seen && r.stream_index >= end_at) &&
                    off >= front_idx - read_total && off < CAP_32 && !slot_full[slot])
                begin
                    ring_bytes[slot] = r.data_byte;
                    slot_full[slot] = 1'b1;
                    pending++;
                    e.accepted = 1'b1;
                end
            end
            else if (r.func == FUNC_END)
            begin
                end_seen = 1'b1;
                end_at = r.stream_index;
            end
            else if (r.func == FUNC_READ)
            begin
                if (front_idx != read_total)
                begin
                    slot = read_total % CAPACITY;
                    e.read_valid = 1'b1;
                    e.read_byte = ring_bytes[slot];
                    slot_full[slot] = 1'b0;
                    read_total++;
                end
            end
            while (front_idx - read_total < CAP_32 && !front_stopped() &&
                   slot_full[front_idx % CAPACITY])
            begin
                front_idx++;
                if (pending > 0)
                    pending--;
            end
            e.assembled_count = 13'(front_idx - read_total);
            e.pending_count = 13'(pending);
            e.stream_ended = front_stopped();
            expected_q.push_back(e);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", got);
                return;
            end
            e = expected_q.pop_front();
            if (got.read_valid !== e.read_valid || got.read_byte !== e.read_byte ||
                got.accepted !== e.accepted || got.assembled_count !== e.assembled_count ||
                got.pending_count !== e.pending_count ||
                got.stream_ended !== e.stream_ended)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p actual %p", e, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    reassembly_scoreboard board;
    int  idle_cycles;
    bit  stimulus_done;
    logic [31:0] base_idx;

    stream_byte_reassembler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // valid drops only when a gap follows, so it is written once per edge
    task automatic send_request(func_t f, logic [31:0] idx, logic [7:0] b);
        int gap;
        req_t r;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r.func = f;
        r.stream_index = idx;
        r.data_byte = b;
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(r);
    endtask

    task automatic push_window_byte(int span);
        send_request(FUNC_PUSH, board.read_total + $urandom_range(0, span), 8'($urandom));
    endtask

    // response side: random stall lengths, some long runs with no stall
    initial
    begin
        int hold;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            board.check_response(rsp);
        end
    end

    // watchdog on cycles with no accepted request or response
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_CAP)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int k;
        int sel;
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        idle_cycles = 0;
        stimulus_done = 1'b0;
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty read, extremes, duplicate, out of window, nop, end
        send_request(FUNC_READ, 32'd0, 8'd0);
        send_request(FUNC_PUSH, 32'd1, 8'hff);
        send_request(FUNC_PUSH, 32'd1, 8'h00);
        send_request(FUNC_PUSH, 32'd0, 8'h00);
        send_request(FUNC_PUSH, CAP_32, 8'h55);
        send_request(FUNC_PUSH, CAP_32 - 1, 8'haa);
        send_request(FUNC_PUSH, 32'hffff_ffff, 8'h12);
        send_request(FUNC_NOP, 32'hffff_ffff, 8'hff);
        send_request(FUNC_READ, 32'hffff_ffff, 8'hff);
        send_request(FUNC_READ, 32'd0, 8'd0);
        send_request(FUNC_PUSH, 32'd0, 8'h01);
        send_request(FUNC_END, 32'd5, 8'd0);
        send_request(FUNC_PUSH, 32'd3, 8'h33);
        send_request(FUNC_PUSH, 32'd4, 8'h44);
        send_request(FUNC_PUSH, 32'd5, 8'h66);
        send_request(FUNC_PUSH, 32'd7, 8'h77);
        send_request(FUNC_END, 32'd6, 8'd0);
        send_request(FUNC_END, 32'hffff_ffff, 8'd0);
        send_request(FUNC_PUSH, 32'd2, 8'h22);
        send_request(FUNC_READ, 32'd0, 8'd0);
        send_request(FUNC_READ, 32'd0, 8'd0);

        // random: mostly pushes near the front, reads, occasional end marks and noise
        for (k = 0; k < RAND_COUNT; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                push_window_byte(($urandom_range(0, 9) == 0) ? 5000 : 24);
            else if (sel < 88)
                send_request(FUNC_READ, $urandom, 8'($urandom));
            else if (sel < 92)
                send_request(FUNC_END, board.front_idx + $urandom_range(0, 60), 8'($urandom));
            else if (sel < 95)
                send_request(FUNC_PUSH, $urandom, 8'($urandom));
            else if (sel < 97)
                send_request(FUNC_NOP, $urandom, 8'($urandom));
            else
                send_request(FUNC_END, 32'hffff_ffff, 8'($urandom));
        end
        req_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial
    begin
        @(posedge rst_n);
        wait (stimulus_done);
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/srb_pkg.sv
sv/srb_ctrl.sv
sv/srb_dp.sv
sv/stream_byte_reassembler.sv
tb/sv/stream_byte_reassembler_test.sv
